[rtl/lmlm_pkg.sv]
// ----------------------------------------------------------------------------
// lmlm_pkg
// Shared constants and types of the LED bar-graph level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package lmlm_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int BYTE_W        = 8;
    localparam int PROD_W        = 20;
    localparam int QUO_W         = 8;
    localparam int BAND_W        = 3;
    localparam int INDEX_W       = 5;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 32;

    localparam int SAT_LEVEL     = 2600;
    localparam int BAND_SPAN     = 520;
    localparam int LEDS_PER_BAND = 5;
    localparam int BAND_COUNT    = 5;
    localparam int LED_TOTAL_DEF = 25;

    localparam logic [BYTE_W-1:0] MAX_BRIGHT_RESET = 8'd64;

    typedef struct packed {
        logic [PROD_W-1:0]   rem;
        logic [SAMPLE_W-1:0] dvs;
        logic [QUO_W-1:0]    quo;
        logic [BYTE_W-1:0]   max_bright;
        logic [BAND_W-1:0]   band;
        logic                nonzero;
    } t_div;

    typedef struct packed {
        logic [BYTE_W-1:0] max_bright;
        logic [QUO_W-1:0]  partial;
        logic [BAND_W-1:0] band;
        logic              nonzero;
    } t_frame;

endpackage

`default_nettype wire

[rtl/lmlm_div_cell.sv]
// ----------------------------------------------------------------------------
// lmlm_div_cell
// One restoring division step; a row of these cells forms the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lmlm_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_adv,
    input  wire                 i_valid,
    input  wire lmlm_pkg::t_div i_data,
    output logic                o_valid,
    output lmlm_pkg::t_div      o_data
);

    logic                        r_valid;
    lmlm_pkg::t_div              r_data;
    lmlm_pkg::t_div              n_data;
    logic [lmlm_pkg::PROD_W:0]   diff;

    always_comb begin
        n_data = i_data;
        diff   = {1'b0, i_data.rem}
               - {1'b0, (lmlm_pkg::PROD_W'(i_data.dvs) << SHIFT)};
        if (!diff[lmlm_pkg::PROD_W]) begin
            n_data.rem        = diff[lmlm_pkg::PROD_W-1:0];
            n_data.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[rtl/lmlm_frame.sv]
// ----------------------------------------------------------------------------
// lmlm_frame
// Frame serializer: turns one band result into one output request per LED.
// ----------------------------------------------------------------------------
`default_nettype none

module lmlm_frame #(
    parameter int LED_TOTAL = lmlm_pkg::LED_TOTAL_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire lmlm_pkg::t_frame             i_data,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [lmlm_pkg::INDEX_W-1:0]      o_led_index,
    output logic [lmlm_pkg::BYTE_W-1:0]       o_red,
    output logic                              o_last
);

    localparam int CW  = $clog2(LED_TOTAL);
    localparam int LBW = $clog2(LED_TOTAL / lmlm_pkg::LEDS_PER_BAND + 1);

    logic                          r_active;
    logic                          r_ovalid;
    logic [CW-1:0]                 r_cnt;
    logic [2:0]                    r_sub;
    logic [LBW-1:0]                r_lband;
    lmlm_pkg::t_frame              r_frame;
    logic [CW-1:0]                 r_oidx;
    logic [lmlm_pkg::BYTE_W-1:0]   r_ored;
    logic                          r_olast;

    logic                          out_free;
    logic                          is_last;
    logic                          take;
    logic [lmlm_pkg::BYTE_W-1:0]   n_level;
    logic [lmlm_pkg::BYTE_W-1:0]   n_red;

    assign out_free = !r_ovalid || i_ready;
    assign is_last  = (r_cnt == CW'(LED_TOTAL - 1));
    assign o_ready  = !r_active || (out_free && is_last);
    assign take     = i_valid && o_ready;

    always_comb begin
        n_level = '0;
        if (r_frame.nonzero && (int'(r_lband) < lmlm_pkg::BAND_COUNT)) begin
            if (int'(r_lband) < int'(r_frame.band)) begin
                n_level = r_frame.max_bright;
            end else if (int'(r_lband) == int'(r_frame.band)) begin
                n_level = r_frame.partial;
            end
        end
        for (int b = 0; b < lmlm_pkg::BYTE_W; b++) begin
            n_red[b] = n_level[lmlm_pkg::BYTE_W-1-b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_sub    <= '0;
            r_lband  <= '0;
        end else begin
            if (out_free) begin
                r_ovalid <= r_active;
            end
            if (out_free && r_active) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_sub == 3'(lmlm_pkg::LEDS_PER_BAND - 1)) begin
                    r_sub   <= '0;
                    r_lband <= r_lband + 1'b1;
                end else begin
                    r_sub <= r_sub + 1'b1;
                end
                if (is_last) begin
                    r_active <= 1'b0;
                end
            end
            if (take) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
                r_sub    <= '0;
                r_lband  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_frame <= i_data;
        end
        if (out_free && r_active) begin
            r_oidx  <= r_cnt;
            r_ored  <= n_red;
            r_olast <= is_last;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_led_index = lmlm_pkg::INDEX_W'(r_oidx);
    assign o_red       = r_ored;
    assign o_last      = r_olast;

endmodule

`default_nettype wire

[rtl/led_matrix_level_meter.sv]
// ----------------------------------------------------------------------------
// led_matrix_level_meter
// Bar-graph level meter: one ADC sample in, one frame of LED words out.
// ----------------------------------------------------------------------------
// Each accepted sample produces LED_TOTAL output requests, one per clock while
// the sink is ready, the final one marked by tlast. The first word of a frame
// follows the accepted sample through two input stages (saturate
// and band select, then brightness times sample) and an eight-cell division
// pipeline. Samples are taken every cycle while the pipeline has room; the
// sustained rate is set by the serializer, which sends one LED word per cycle
// while the sink is ready.
`default_nettype none

module led_matrix_level_meter #(
    parameter int LED_TOTAL = lmlm_pkg::LED_TOTAL_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire  [lmlm_pkg::BYTE_W-1:0]          i_cfg_wr_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] sample, [15:12] zero.
    input  wire  [lmlm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [4:0] led_index, [12:5] green, [20:13] red, [28:21] blue, [31:29] zero.
    output logic [lmlm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int NC = lmlm_pkg::QUO_W;

    logic [lmlm_pkg::BYTE_W-1:0]     r_max_bright;

    logic                            adv;
    logic [lmlm_pkg::SAMPLE_W-1:0]   n_val;
    logic [lmlm_pkg::BAND_W-1:0]     n_band;

    logic                            r_a_valid;
    logic [lmlm_pkg::SAMPLE_W-1:0]   r_a_val;
    logic [lmlm_pkg::BAND_W-1:0]     r_a_band;
    logic [lmlm_pkg::BYTE_W-1:0]     r_a_max;
    logic                            r_a_nz;

    logic                            r_b_valid;
    lmlm_pkg::t_div                  r_b_data;

    logic                            chain_valid [NC+1];
    lmlm_pkg::t_div                  chain_data  [NC+1];

    lmlm_pkg::t_frame                frame_in;
    logic                            frame_ready;
    logic [lmlm_pkg::INDEX_W-1:0]    led_index;
    logic [lmlm_pkg::BYTE_W-1:0]     red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bright <= lmlm_pkg::MAX_BRIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_bright <= i_cfg_wr_data;
        end
    end

    assign adv           = !chain_valid[NC] || frame_ready;
    assign s_axis_tready = adv;

    always_comb begin
        if (s_axis_tdata[lmlm_pkg::SAMPLE_W-1:0] > lmlm_pkg::SAMPLE_W'(lmlm_pkg::SAT_LEVEL)) begin
            n_val = lmlm_pkg::SAMPLE_W'(lmlm_pkg::SAT_LEVEL);
        end else begin
            n_val = s_axis_tdata[lmlm_pkg::SAMPLE_W-1:0];
        end
        priority if (n_val >= lmlm_pkg::SAMPLE_W'(4 * lmlm_pkg::BAND_SPAN)) begin
            n_band = 3'd4;
        end else if (n_val >= lmlm_pkg::SAMPLE_W'(3 * lmlm_pkg::BAND_SPAN)) begin
            n_band = 3'd3;
        end else if (n_val >= lmlm_pkg::SAMPLE_W'(2 * lmlm_pkg::BAND_SPAN)) begin
            n_band = 3'd2;
        end else if (n_val >= lmlm_pkg::SAMPLE_W'(lmlm_pkg::BAND_SPAN)) begin
            n_band = 3'd1;
        end else begin
            n_band = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= s_axis_tvalid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_val           <= n_val;
            r_a_band          <= n_band;
            r_a_max           <= r_max_bright;
            r_a_nz            <= (n_val != '0);
            r_b_data.rem      <= lmlm_pkg::PROD_W'(r_a_max) * lmlm_pkg::PROD_W'(r_a_val);
            r_b_data.dvs      <= lmlm_pkg::SAMPLE_W'(lmlm_pkg::BAND_SPAN * (int'(r_a_band) + 1));
            r_b_data.quo      <= '0;
            r_b_data.max_bright <= r_a_max;
            r_b_data.band     <= r_a_band;
            r_b_data.nonzero  <= r_a_nz;
        end
    end

    assign chain_valid[0] = r_b_valid;
    assign chain_data[0]  = r_b_data;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        lmlm_div_cell #(
            .SHIFT (NC - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    assign frame_in.max_bright = chain_data[NC].max_bright;
    assign frame_in.partial    = chain_data[NC].quo;
    assign frame_in.band       = chain_data[NC].band;
    assign frame_in.nonzero    = chain_data[NC].nonzero;

    lmlm_frame #(
        .LED_TOTAL (LED_TOTAL)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (chain_valid[NC]),
        .o_ready     (frame_ready),
        .i_data      (frame_in),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_led_index (led_index),
        .o_red       (red),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, 8'h00, red, 8'h00, led_index};

`ifndef ASSERT_OFF
    a_last_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast)
            |-> (m_axis_tdata[4:0] == lmlm_pkg::INDEX_W'(LED_TOTAL - 1)))
        else $error("tlast on a word that is not the final LED");

    a_index_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
            |=> (m_axis_tvalid && (m_axis_tdata[4:0] == $past(m_axis_tdata[4:0]) + 5'd1)))
        else $error("LED words of a frame are not contiguous");

    a_dark_channels : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[12:5] == 8'h00) && (m_axis_tdata[28:21] == 8'h00)))
        else $error("green or blue byte is not zero");
`endif

endmodule

`default_nettype wire
